// ===== design/lavm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and constants of the look-at view matrix block: Q16.16
// formats, unit vector width, row codes and the side data structs.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int FX_W   = 32;
  localparam int FRAC_W = 16;
  // unit vector components lie in [-1.0, 1.0] in Q16.16, plus a sign bit
  localparam int UNIT_W = FRAC_W + 2;
  // normalizer works on magnitudes scaled into [2^29, 2^30)
  localparam int NRM_W  = 30;

  localparam logic signed [FX_W-1:0] FX_ONE = 32'sh0001_0000;

  // row codes of the emitted matrix
  localparam logic [1:0] ROW_X    = 2'd0;
  localparam logic [1:0] ROW_Y    = 2'd1;
  localparam logic [1:0] ROW_Z    = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
    fx_t z;
  } fx3_t;

  typedef struct packed {
    unit_t x;
    unit_t y;
    unit_t z;
  } unit3_t;

  // data that rides along the first normalizer
  typedef struct packed {
    fx3_t eye;
    fx3_t up;
  } n1_side_t;

  // data that rides along the second normalizer
  typedef struct packed {
    fx3_t   eye;
    unit3_t r2;
    logic   z1;
  } n2_side_t;

endpackage

// ===== design/lavm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm channel interfaces
// Valid/ready channels of the view matrix block: camera requests in,
// matrix rows out, and the handedness register write.
// ----------------------------------------------------------------------------

// camera request: eye, target and up in Q16.16
interface lavm_in_if;
  logic          valid;
  logic          ready;
  lavm_pkg::fx_t eye_x;
  lavm_pkg::fx_t eye_y;
  lavm_pkg::fx_t eye_z;
  lavm_pkg::fx_t target_x;
  lavm_pkg::fx_t target_y;
  lavm_pkg::fx_t target_z;
  lavm_pkg::fx_t up_x;
  lavm_pkg::fx_t up_y;
  lavm_pkg::fx_t up_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
    output ready
  );
endinterface

// one matrix row
interface lavm_out_if;
  logic          valid;
  logic          ready;
  logic [1:0]    row_index;
  lavm_pkg::fx_t col0;
  lavm_pkg::fx_t col1;
  lavm_pkg::fx_t col2;
  lavm_pkg::fx_t col3;
  logic          last_row;
  logic          degenerate;

  modport source (
    output valid, row_index, col0, col1, col2, col3, last_row, degenerate,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, col3, last_row, degenerate,
    output ready
  );
endinterface

// handedness register write
interface lavm_cfg_if;
  logic valid;
  logic ready;
  logic right_handed;

  modport source (
    output valid, right_handed,
    input  ready
  );
  modport sink (
    input  valid, right_handed,
    output ready
  );
endinterface

// ===== design/lavm_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer: scales the magnitudes so the largest lies
// in [2^29, 2^30), takes the floor square root of the sum of squares one
// bit per stage, then divides each component one quotient bit per stage.
// Output is Q16.16 with the input signs; a zero vector gives zero and flag.
// ----------------------------------------------------------------------------
module lavm_norm #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic signed [IN_W-1:0] v [3],
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  vld_out,
  output lavm_pkg::unit_t       r [3],
  output logic                  zero,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int M_W    = lavm_pkg::NRM_W;
  localparam int F_W    = lavm_pkg::FRAC_W;
  localparam int L      = $clog2(IN_W);
  localparam int SQ_W   = 2 * M_W + 2;
  localparam int RT_N   = M_W + 1;
  localparam int LEN_W  = M_W + 1;
  localparam int Q_W    = F_W + 1;
  localparam int NUM_W  = M_W + F_W + 1;
  localparam int ST_SQ  = L + 2;
  localparam int ST_SUM = L + 3;
  localparam int ST_RT  = L + 4;
  localparam int ST_DV  = ST_RT + RT_N;
  localparam int ST_OUT = ST_DV + Q_W;
  localparam int NS     = ST_OUT + 1;

  logic              vld [NS];
  logic [SIDE_W-1:0] sd  [NS];
  logic [2:0]        ng  [NS];
  logic              zr  [1:NS-1];

  logic [IN_W-1:0]  mag0 [3];
  logic [IN_W-1:0]  mx_next;
  logic [IN_W-1:0]  cm [1:L+1][3];
  logic [IN_W-1:0]  mx [1:L+1];
  logic [M_W-1:0]   mm [ST_SQ:ST_DV-1][3];
  logic [2*M_W-1:0] sq [3];
  logic [SQ_W-1:0]  rn [ST_SUM:ST_DV-1];
  logic [SQ_W-1:0]  rs [ST_SUM:ST_DV-1];
  logic [NUM_W-1:0] rm [ST_DV:ST_OUT-1][3];
  logic [Q_W-1:0]   qt [ST_DV:ST_OUT-1][3];
  logic [LEN_W-1:0] ln [ST_DV:ST_OUT-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
    end
  end

  // side data, signs and zero flag travel with the item
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      ng[0] <= {v[2][IN_W-1], v[1][IN_W-1], v[0][IN_W-1]};
      for (int i = 1; i < NS; i++) begin
        sd[i] <= sd[i-1];
        ng[i] <= ng[i-1];
      end
      zr[1] <= ((mag0[0] | mag0[1] | mag0[2]) == '0);
      for (int i = 2; i < NS; i++) zr[i] <= zr[i-1];
    end
  end

  // stage 0: magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag0[k] <= v[k][IN_W-1] ? $unsigned(-v[k]) : $unsigned(v[k]);
      end
    end
  end

  // stage 1: largest magnitude
  always_comb begin
    mx_next = mag0[0];
    if (mag0[1] > mx_next) mx_next = mag0[1];
    if (mag0[2] > mx_next) mx_next = mag0[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx[1] <= mx_next;
      for (int k = 0; k < 3; k++) cm[1][k] <= mag0[k];
    end
  end

  // left-justify all three by the leading zeros of the largest
  for (genvar s = 0; s < L; s++) begin : g_shift
    localparam int SH = 1 << (L - 1 - s);
    always_ff @(posedge clk) begin
      if (en) begin
        if (mx[s+1][IN_W-1 -: SH] == '0) begin
          mx[s+2] <= mx[s+1] << SH;
          for (int k = 0; k < 3; k++) cm[s+2][k] <= cm[s+1][k] << SH;
        end else begin
          mx[s+2] <= mx[s+1];
          for (int k = 0; k < 3; k++) cm[s+2][k] <= cm[s+1][k];
        end
      end
    end
  end

  // squares of the scaled magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mm[ST_SQ][k] <= cm[L+1][k][IN_W-1 -: M_W];
        sq[k] <= (2*M_W)'(cm[L+1][k][IN_W-1 -: M_W]) * (2*M_W)'(cm[L+1][k][IN_W-1 -: M_W]);
      end
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      rn[ST_SUM] <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
      rs[ST_SUM] <= '0;
      for (int k = 0; k < 3; k++) mm[ST_SUM][k] <= mm[ST_SQ][k];
    end
  end

  // floor square root, one result bit per stage
  for (genvar j = 0; j < RT_N; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] B4 = SQ_W'(1) << (2 * (M_W - j));
    logic [SQ_W:0] trial;
    logic          fits;

    always_comb begin
      trial = {1'b0, rs[ST_RT+j-1]} + {1'b0, B4};
      fits  = ({1'b0, rn[ST_RT+j-1]} >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (fits) begin
          rn[ST_RT+j] <= rn[ST_RT+j-1] - trial[SQ_W-1:0];
          rs[ST_RT+j] <= (rs[ST_RT+j-1] >> 1) + B4;
        end else begin
          rn[ST_RT+j] <= rn[ST_RT+j-1];
          rs[ST_RT+j] <= rs[ST_RT+j-1] >> 1;
        end
        for (int k = 0; k < 3; k++) mm[ST_RT+j][k] <= mm[ST_RT+j-1][k];
      end
    end
  end

  // rounded division by the length, one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    localparam int QB = Q_W - 1 - j;
    logic [NUM_W-1:0] rsrc [3];
    logic [Q_W-1:0]   qsrc [3];
    logic [LEN_W-1:0] lsrc;
    logic [NUM_W-1:0] dv;

    if (j == 0) begin : g_first
      // numerator is m * 2^16 + len / 2
      always_comb begin
        lsrc = rs[ST_DV-1][LEN_W-1:0];
        for (int k = 0; k < 3; k++) begin
          rsrc[k] = (NUM_W'(mm[ST_DV-1][k]) << F_W) + NUM_W'(lsrc[LEN_W-1:1]);
          qsrc[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        lsrc = ln[ST_DV+j-1];
        for (int k = 0; k < 3; k++) begin
          rsrc[k] = rm[ST_DV+j-1][k];
          qsrc[k] = qt[ST_DV+j-1][k];
        end
      end
    end

    assign dv = NUM_W'(lsrc) << QB;

    always_ff @(posedge clk) begin
      if (en) begin
        ln[ST_DV+j] <= lsrc;
        for (int k = 0; k < 3; k++) begin
          if (rsrc[k] >= dv) begin
            rm[ST_DV+j][k] <= rsrc[k] - dv;
            qt[ST_DV+j][k] <= qsrc[k] | (Q_W'(1) << QB);
          end else begin
            rm[ST_DV+j][k] <= rsrc[k];
            qt[ST_DV+j][k] <= qsrc[k];
          end
        end
      end
    end
  end

  // apply signs, zero vector gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (zr[ST_OUT-1]) begin
          r[k] <= '0;
        end else if (ng[ST_OUT-1][k]) begin
          r[k] <= -lavm_pkg::unit_t'(qt[ST_OUT-1][k]);
        end else begin
          r[k] <= lavm_pkg::unit_t'(qt[ST_OUT-1][k]);
        end
      end
    end
  end

  assign vld_out  = vld[NS-1];
  assign side_out = sd[NS-1];
  assign zero     = zr[NS-1];

endmodule

// ===== design/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds the 4x4 camera view matrix from eye, target and up in Q16.16.
// ----------------------------------------------------------------------------
// One camera request yields four row results, rows 0 to 2 carrying the x, y
// and z components of the three basis vectors and row 3 the translation with
// 1.0 in column 3. In steady state the request rate is set by the four result
// rows per request; the pipeline itself takes one request per cycle while not
// stalled and absorbs bursts. Most of the time from request to first row is
// spent in the two normalizers (bit-serial square root and division, one bit
// per stage). A backpressured result stalls the whole pipeline without losing
// anything. degenerate is set on all four rows when the direction or up x
// direction has zero length; columns 0 and 1 of those rows then come out zero.
// right_handed selects eye - target as the direction and is to be written by
// the user only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input logic         clk,
  input logic         rst,
  lavm_cfg_if.sink    cfg,
  lavm_in_if.sink     camera,
  lavm_out_if.source  rows
);

  localparam int DIR_W = lavm_pkg::FX_W + 1;
  localparam int U_W   = lavm_pkg::UNIT_W;
  localparam int P1_W  = lavm_pkg::FX_W + U_W;
  localparam int TX_W  = P1_W + 1;
  localparam int P2_W  = 2 * U_W;
  localparam int RS_W  = P2_W + 2;
  localparam int R1_W  = RS_W - lavm_pkg::FRAC_W;
  localparam int P3_W  = lavm_pkg::FX_W + R1_W;
  localparam int ACC_W = P3_W + 2;
  localparam int RR_W  = ACC_W + 1;
  localparam int RD_W  = RR_W - lavm_pkg::FRAC_W;
  localparam int NV_W  = RD_W + 1;
  localparam logic signed [NV_W-1:0] SAT_HI = NV_W'(32'sh7FFF_FFFF);
  localparam logic signed [NV_W-1:0] SAT_LO = NV_W'(-33'sh0_8000_0000);

  logic en;
  logic right_handed;

  // handedness register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_handed <= 1'b0;
    end else if (cfg.valid) begin
      right_handed <= cfg.right_handed;
    end
  end

  // input stage: direction vector
  logic                     p0_vld;
  lavm_pkg::n1_side_t       p0_side;
  logic signed [DIR_W-1:0]  p0_dir [3];

  assign camera.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else if (en) begin
      p0_vld <= camera.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_side.eye.x <= camera.eye_x;
      p0_side.eye.y <= camera.eye_y;
      p0_side.eye.z <= camera.eye_z;
      p0_side.up.x  <= camera.up_x;
      p0_side.up.y  <= camera.up_y;
      p0_side.up.z  <= camera.up_z;
      if (right_handed) begin
        p0_dir[0] <= DIR_W'(camera.eye_x) - DIR_W'(camera.target_x);
        p0_dir[1] <= DIR_W'(camera.eye_y) - DIR_W'(camera.target_y);
        p0_dir[2] <= DIR_W'(camera.eye_z) - DIR_W'(camera.target_z);
      end else begin
        p0_dir[0] <= DIR_W'(camera.target_x) - DIR_W'(camera.eye_x);
        p0_dir[1] <= DIR_W'(camera.target_y) - DIR_W'(camera.eye_y);
        p0_dir[2] <= DIR_W'(camera.target_z) - DIR_W'(camera.eye_z);
      end
    end
  end

  // r2 = normalize(dir)
  logic               n1_vld;
  lavm_pkg::unit_t    n1_r [3];
  logic               n1_z;
  lavm_pkg::n1_side_t n1_side;

  lavm_norm #(
    .IN_W   (DIR_W),
    .SIDE_W ($bits(lavm_pkg::n1_side_t))
  ) u_norm_dir (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (p0_vld),
    .v        (p0_dir),
    .side_in  (p0_side),
    .vld_out  (n1_vld),
    .r        (n1_r),
    .zero     (n1_z),
    .side_out (n1_side)
  );

  // up x r2: products
  logic                    c1_vld;
  logic signed [P1_W-1:0]  c1_p [6];
  lavm_pkg::n2_side_t      c1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
    end else if (en) begin
      c1_vld <= n1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p[0] <= P1_W'(n1_side.up.y) * P1_W'(n1_r[2]);
      c1_p[1] <= P1_W'(n1_side.up.z) * P1_W'(n1_r[1]);
      c1_p[2] <= P1_W'(n1_side.up.z) * P1_W'(n1_r[0]);
      c1_p[3] <= P1_W'(n1_side.up.x) * P1_W'(n1_r[2]);
      c1_p[4] <= P1_W'(n1_side.up.x) * P1_W'(n1_r[1]);
      c1_p[5] <= P1_W'(n1_side.up.y) * P1_W'(n1_r[0]);
      c1_side.eye  <= n1_side.eye;
      c1_side.r2.x <= n1_r[0];
      c1_side.r2.y <= n1_r[1];
      c1_side.r2.z <= n1_r[2];
      c1_side.z1   <= n1_z;
    end
  end

  // up x r2: differences
  logic                   c2_vld;
  logic signed [TX_W-1:0] c2_t [3];
  lavm_pkg::n2_side_t     c2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_vld <= 1'b0;
    end else if (en) begin
      c2_vld <= c1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_t[0] <= TX_W'(c1_p[0]) - TX_W'(c1_p[1]);
      c2_t[1] <= TX_W'(c1_p[2]) - TX_W'(c1_p[3]);
      c2_t[2] <= TX_W'(c1_p[4]) - TX_W'(c1_p[5]);
      c2_side <= c1_side;
    end
  end

  // r0 = normalize(up x r2)
  logic               n2_vld;
  lavm_pkg::unit_t    n2_r [3];
  logic               n2_z;
  lavm_pkg::n2_side_t n2_side;

  lavm_norm #(
    .IN_W   (TX_W),
    .SIDE_W ($bits(lavm_pkg::n2_side_t))
  ) u_norm_side (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (c2_vld),
    .v        (c2_t),
    .side_in  (c2_side),
    .vld_out  (n2_vld),
    .r        (n2_r),
    .zero     (n2_z),
    .side_out (n2_side)
  );

  // r2 x r0: products
  logic                   c3_vld;
  logic signed [P2_W-1:0] c3_p [6];
  lavm_pkg::fx3_t         c3_eye;
  lavm_pkg::unit_t        c3_r0 [3];
  lavm_pkg::unit_t        c3_r2 [3];
  logic                   c3_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_vld <= 1'b0;
    end else if (en) begin
      c3_vld <= n2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_p[0]  <= P2_W'(n2_side.r2.y) * P2_W'(n2_r[2]);
      c3_p[1]  <= P2_W'(n2_side.r2.z) * P2_W'(n2_r[1]);
      c3_p[2]  <= P2_W'(n2_side.r2.z) * P2_W'(n2_r[0]);
      c3_p[3]  <= P2_W'(n2_side.r2.x) * P2_W'(n2_r[2]);
      c3_p[4]  <= P2_W'(n2_side.r2.x) * P2_W'(n2_r[1]);
      c3_p[5]  <= P2_W'(n2_side.r2.y) * P2_W'(n2_r[0]);
      c3_eye   <= n2_side.eye;
      c3_r2[0] <= n2_side.r2.x;
      c3_r2[1] <= n2_side.r2.y;
      c3_r2[2] <= n2_side.r2.z;
      c3_z     <= n2_side.z1 | n2_z;
      for (int k = 0; k < 3; k++) c3_r0[k] <= n2_r[k];
    end
  end

  // r1: differences rounded to Q16.16
  logic signed [RS_W-1:0] c4_sum [3];
  logic                   c4_vld;
  logic signed [R1_W-1:0] c4_r1 [3];
  lavm_pkg::fx3_t         c4_eye;
  lavm_pkg::unit_t        c4_r0 [3];
  lavm_pkg::unit_t        c4_r2 [3];
  logic                   c4_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c4_sum[k] = RS_W'(c3_p[2*k]) - RS_W'(c3_p[2*k+1])
                + RS_W'(1 << (lavm_pkg::FRAC_W - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4_vld <= 1'b0;
    end else if (en) begin
      c4_vld <= c3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c4_r1[k] <= c4_sum[k][RS_W-1:lavm_pkg::FRAC_W];
        c4_r0[k] <= c3_r0[k];
        c4_r2[k] <= c3_r2[k];
      end
      c4_eye <= c3_eye;
      c4_z   <= c3_z;
    end
  end

  // translation: products r_i[k] * eye[k]
  lavm_pkg::fx_t          eye_k [3];
  logic                   c5_vld;
  logic signed [P3_W-1:0] c5_p [3][3];
  lavm_pkg::fx_t          c5_r0 [3];
  lavm_pkg::fx_t          c5_r1 [3];
  lavm_pkg::fx_t          c5_r2 [3];
  logic                   c5_z;

  assign eye_k[0] = c4_eye.x;
  assign eye_k[1] = c4_eye.y;
  assign eye_k[2] = c4_eye.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      c5_vld <= 1'b0;
    end else if (en) begin
      c5_vld <= c4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c5_p[0][k] <= P3_W'(c4_r0[k]) * P3_W'(eye_k[k]);
        c5_p[1][k] <= P3_W'(c4_r1[k]) * P3_W'(eye_k[k]);
        c5_p[2][k] <= P3_W'(c4_r2[k]) * P3_W'(eye_k[k]);
        c5_r0[k]   <= lavm_pkg::FX_W'(c4_r0[k]);
        c5_r1[k]   <= lavm_pkg::FX_W'(c4_r1[k]);
        c5_r2[k]   <= lavm_pkg::FX_W'(c4_r2[k]);
      end
      c5_z <= c4_z;
    end
  end

  // translation: dot product sums
  logic                    c6_vld;
  logic signed [ACC_W-1:0] c6_acc [3];
  lavm_pkg::fx_t           c6_r0 [3];
  lavm_pkg::fx_t           c6_r1 [3];
  lavm_pkg::fx_t           c6_r2 [3];
  logic                    c6_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      c6_vld <= 1'b0;
    end else if (en) begin
      c6_vld <= c5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c6_acc[i] <= ACC_W'(c5_p[i][0]) + ACC_W'(c5_p[i][1]) + ACC_W'(c5_p[i][2]);
      end
      c6_r0 <= c5_r0;
      c6_r1 <= c5_r1;
      c6_r2 <= c5_r2;
      c6_z  <= c5_z;
    end
  end

  // translation: round, negate, saturate
  logic signed [RR_W-1:0] d_rr  [3];
  logic signed [RD_W-1:0] d_rnd [3];
  logic signed [NV_W-1:0] d_neg [3];
  lavm_pkg::fx_t          d_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_rr[i]  = RR_W'(c6_acc[i]) + RR_W'(1 << (lavm_pkg::FRAC_W - 1));
      d_rnd[i] = d_rr[i][RR_W-1:lavm_pkg::FRAC_W];
      d_neg[i] = -NV_W'(d_rnd[i]);
      if (d_neg[i] > SAT_HI) begin
        d_sat[i] = SAT_HI[lavm_pkg::FX_W-1:0];
      end else if (d_neg[i] < SAT_LO) begin
        d_sat[i] = SAT_LO[lavm_pkg::FX_W-1:0];
      end else begin
        d_sat[i] = d_neg[i][lavm_pkg::FX_W-1:0];
      end
    end
  end

  logic          fin_vld;
  lavm_pkg::fx_t fin_d  [3];
  lavm_pkg::fx_t fin_r0 [3];
  lavm_pkg::fx_t fin_r1 [3];
  lavm_pkg::fx_t fin_r2 [3];
  logic          fin_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else if (en) begin
      fin_vld <= c6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_d  <= d_sat;
      fin_r0 <= c6_r0;
      fin_r1 <= c6_r1;
      fin_r2 <= c6_r2;
      fin_z  <= c6_z;
    end
  end

  // row serializer: holds one matrix and sends its four rows
  logic          busy;
  logic [1:0]    row;
  logic          ser_take;
  lavm_pkg::fx_t m_d  [3];
  lavm_pkg::fx_t m_r0 [3];
  lavm_pkg::fx_t m_r1 [3];
  lavm_pkg::fx_t m_r2 [3];
  logic          m_z;

  assign ser_take = !busy || (row == lavm_pkg::ROW_LAST && rows.ready);
  assign en       = !fin_vld || ser_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= lavm_pkg::ROW_X;
    end else if (ser_take) begin
      busy <= fin_vld;
      row  <= lavm_pkg::ROW_X;
    end else if (rows.ready) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take && fin_vld) begin
      m_d  <= fin_d;
      m_r0 <= fin_r0;
      m_r1 <= fin_r1;
      m_r2 <= fin_r2;
      m_z  <= fin_z;
    end
  end

  // row select
  always_comb begin
    rows.valid      = busy;
    rows.row_index  = row;
    rows.degenerate = m_z;
    rows.last_row   = 1'b0;
    rows.col3       = '0;
    case (row)
      lavm_pkg::ROW_X: begin
        rows.col0 = m_r0[0];
        rows.col1 = m_r1[0];
        rows.col2 = m_r2[0];
      end
      lavm_pkg::ROW_Y: begin
        rows.col0 = m_r0[1];
        rows.col1 = m_r1[1];
        rows.col2 = m_r2[1];
      end
      lavm_pkg::ROW_Z: begin
        rows.col0 = m_r0[2];
        rows.col1 = m_r1[2];
        rows.col2 = m_r2[2];
      end
      lavm_pkg::ROW_LAST: begin
        rows.col0     = m_d[0];
        rows.col1     = m_d[1];
        rows.col2     = m_d[2];
        rows.col3     = lavm_pkg::FX_ONE;
        rows.last_row = 1'b1;
      end
      default: begin
        rows.col0 = '0;
        rows.col1 = '0;
        rows.col2 = '0;
      end
    endcase
  end

endmodule

// ===== design/lavm_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_chk
// Port-level checks of the view matrix block: row sequencing, row framing
// and the constant column, attached to the top level with bind.
// ----------------------------------------------------------------------------
module lavm_chk (
  input logic          clk,
  input logic          rst,
  input logic          valid,
  input logic          ready,
  input logic [1:0]    row_index,
  input lavm_pkg::fx_t col0,
  input lavm_pkg::fx_t col3,
  input logic          last_row,
  input logic          degenerate
);

  // rows of one matrix follow each other in order
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (valid && ready && !last_row) |=> (valid && row_index == $past(row_index) + 2'd1))
    else $error("row sequence broken");

  // last_row marks exactly the translation row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_row == (row_index == lavm_pkg::ROW_LAST)))
    else $error("last_row does not match row_index");

  // column 3 is 0 on basis rows and 1.0 on the translation row
  a_col3: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_row ? (col3 == lavm_pkg::FX_ONE) : (col3 == '0)))
    else $error("column 3 wrong");

  // degenerate flag is the same on every row of a matrix
  a_degen: assert property (@(posedge clk) disable iff (rst)
    (valid && ready && !last_row) |=> (degenerate == $past(degenerate)))
    else $error("degenerate changed within a matrix");

  // a stalled row holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(row_index) && $stable(col0)))
    else $error("stalled row changed");

endmodule

bind look_at_view_matrix lavm_chk u_lavm_chk (
  .clk        (clk),
  .rst        (rst),
  .valid      (rows.valid),
  .ready      (rows.ready),
  .row_index  (rows.row_index),
  .col0       (rows.col0),
  .col3       (rows.col3),
  .last_row   (rows.last_row),
  .degenerate (rows.degenerate)
);

// ===== tb/sv/tb_look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Drives camera requests with random gaps, stalls the row channel at random
// and checks every emitted row against a fixed-point view matrix predictor.
// Both handedness settings are visited, each written while idle.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;

  localparam int LATENCY    = 126;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    lavm_pkg::fx_t ex, ey, ez, tx, ty, tz, ux, uy, uz;
  } camera_req_t;

  typedef struct {
    logic [1:0]    row_index;
    lavm_pkg::fx_t col0, col1, col2, col3;
    logic          last_row;
    logic          degenerate;
  } matrix_row_t;

  logic clk;
  logic rst;

  lavm_cfg_if cfg_ch ();
  lavm_in_if  cam_ch ();
  lavm_out_if row_ch ();

  look_at_view_matrix i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch.sink),
    .camera (cam_ch.sink),
    .rows   (row_ch.source)
  );

  camera_req_t pending_reqs[$];
  matrix_row_t expected_rows[$];
  logic        handed_mode;
  int          fail_count;
  int          idle_cycles;
  int          send_gap;
  int          stall_gap;
  logic        stalls_on;
  logic        gaps_on;
  logic        cam_taken;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // predictor helpers
  // ---------------------------------------------------------------------------
  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic lavm_pkg::fx_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return lavm_pkg::fx_t'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // unit vector of v, returns 1 when v has zero length
  function automatic logic unit_vec(input longint v[3], output longint r[3]);
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned len;
    longint unsigned q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q    = ((m[i] << 16) + (len >> 1)) / len;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // expected four rows of one camera request
  task automatic predict_view_rows(camera_req_t c);
    longint eye[3], tgt[3], up[3], dir[3], t[3];
    longint r0[3], r1[3], r2[3], d[3];
    longint acc;
    logic   degen;
    matrix_row_t row;
    eye = '{c.ex, c.ey, c.ez};
    tgt = '{c.tx, c.ty, c.tz};
    up  = '{c.ux, c.uy, c.uz};
    for (int i = 0; i < 3; i++)
      dir[i] = handed_mode ? eye[i] - tgt[i] : tgt[i] - eye[i];
    degen = unit_vec(dir, r2);
    cross_prod(up, r2, t);
    if (unit_vec(t, r0)) degen = 1'b1;
    cross_prod(r2, r0, t);
    for (int i = 0; i < 3; i++) r1[i] = round_q16(t[i]);
    acc  = r0[0] * eye[0] + r0[1] * eye[1] + r0[2] * eye[2];
    d[0] = -round_q16(acc);
    acc  = r1[0] * eye[0] + r1[1] * eye[1] + r1[2] * eye[2];
    d[1] = -round_q16(acc);
    acc  = r2[0] * eye[0] + r2[1] * eye[1] + r2[2] * eye[2];
    d[2] = -round_q16(acc);
    for (int k = 0; k < 3; k++) begin
      row.row_index  = 2'(k);
      row.col0       = clamp32(r0[k]);
      row.col1       = clamp32(r1[k]);
      row.col2       = clamp32(r2[k]);
      row.col3       = '0;
      row.last_row   = 1'b0;
      row.degenerate = degen;
      expected_rows.push_back(row);
    end
    row.row_index  = lavm_pkg::ROW_LAST;
    row.col0       = clamp32(d[0]);
    row.col1       = clamp32(d[1]);
    row.col2       = clamp32(d[2]);
    row.col3       = lavm_pkg::FX_ONE;
    row.last_row   = 1'b1;
    row.degenerate = degen;
    expected_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  // request taken at the last rising edge
  always @(posedge clk) begin
    cam_taken <= !rst && cam_ch.valid && cam_ch.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      cam_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else if (cam_ch.valid && !cam_taken) begin
      // hold the request
    end else if (send_gap > 0) begin
      cam_ch.valid <= 1'b0;
      send_gap     <= send_gap - 1;
    end else if (cam_taken && gaps_on && $urandom_range(0, 1) == 0) begin
      // request taken at the last edge, pause before the next
      cam_ch.valid <= 1'b0;
      send_gap     <= $urandom_range(0, 16);
    end else if (pending_reqs.size() > 0) begin
      camera_req_t c;
      c = pending_reqs.pop_front();
      cam_ch.valid    <= 1'b1;
      cam_ch.eye_x    <= c.ex;
      cam_ch.eye_y    <= c.ey;
      cam_ch.eye_z    <= c.ez;
      cam_ch.target_x <= c.tx;
      cam_ch.target_y <= c.ty;
      cam_ch.target_z <= c.tz;
      cam_ch.up_x     <= c.ux;
      cam_ch.up_y     <= c.uy;
      cam_ch.up_z     <= c.uz;
    end else begin
      cam_ch.valid <= 1'b0;
    end
  end

  // row sink stalls
  always @(negedge clk) begin
    if (rst) begin
      row_ch.ready <= 1'b0;
      stall_gap    <= 0;
    end else if (stall_gap > 0) begin
      row_ch.ready <= 1'b0;
      stall_gap    <= stall_gap - 1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      row_ch.ready <= 1'b0;
      stall_gap    <= $urandom_range(0, 16);
    end else begin
      row_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on request, compare on row
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cam_ch.valid && cam_ch.ready) begin
        camera_req_t c;
        c = '{cam_ch.eye_x, cam_ch.eye_y, cam_ch.eye_z, cam_ch.target_x,
              cam_ch.target_y, cam_ch.target_z, cam_ch.up_x, cam_ch.up_y,
              cam_ch.up_z};
        predict_view_rows(c);
      end
      if (row_ch.valid && row_ch.ready) begin
        matrix_row_t e;
        if (expected_rows.size() == 0) begin
          $error("unexpected row %0d", row_ch.row_index);
          fail_count++;
        end else begin
          e = expected_rows.pop_front();
          if (row_ch.row_index !== e.row_index) begin
            $error("row_index: expected %0d got %0d", e.row_index, row_ch.row_index);
            fail_count++;
          end
          if (row_ch.col0 !== e.col0) begin
            $error("col0: expected %0d got %0d", e.col0, row_ch.col0);
            fail_count++;
          end
          if (row_ch.col1 !== e.col1) begin
            $error("col1: expected %0d got %0d", e.col1, row_ch.col1);
            fail_count++;
          end
          if (row_ch.col2 !== e.col2) begin
            $error("col2: expected %0d got %0d", e.col2, row_ch.col2);
            fail_count++;
          end
          if (row_ch.col3 !== e.col3) begin
            $error("col3: expected %0d got %0d", e.col3, row_ch.col3);
            fail_count++;
          end
          if (row_ch.last_row !== e.last_row) begin
            $error("last_row: expected %0b got %0b", e.last_row, row_ch.last_row);
            fail_count++;
          end
          if (row_ch.degenerate !== e.degenerate) begin
            $error("degenerate: expected %0b got %0b", e.degenerate, row_ch.degenerate);
            fail_count++;
          end
        end
      end
      // watchdog
      if ((cam_ch.valid && cam_ch.ready) || (row_ch.valid && row_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic lavm_pkg::fx_t rand_coord();
    case ($urandom_range(0, 5))
      0:       return lavm_pkg::fx_t'($urandom);
      1:       return lavm_pkg::fx_t'($urandom_range(0, 8)) - 4;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return lavm_pkg::fx_t'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic camera_req_t make_req(
    lavm_pkg::fx_t ex, lavm_pkg::fx_t ey, lavm_pkg::fx_t ez,
    lavm_pkg::fx_t tx, lavm_pkg::fx_t ty, lavm_pkg::fx_t tz,
    lavm_pkg::fx_t ux, lavm_pkg::fx_t uy, lavm_pkg::fx_t uz);
    camera_req_t c;
    c = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    return c;
  endfunction

  function automatic camera_req_t rand_req();
    camera_req_t c;
    c = make_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord());
    // occasional degenerate setups: target on eye, up along the direction, or up zero
    case ($urandom_range(0, 15))
      0: begin c.tx = c.ex; c.ty = c.ey; c.tz = c.ez; end
      1: begin c.ux = c.tx - c.ex; c.uy = c.ty - c.ey; c.uz = c.tz - c.ez; end
      2: begin c.ux = 0; c.uy = 0; c.uz = 0; end
      default: ;
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rows.size() > 0 || cam_ch.valid)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_handedness(logic v);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.right_handed <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    handed_mode = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    lavm_pkg::fx_t mx, mn, one;
    mx  = 32'sh7fffffff;
    mn  = 32'sh80000000;
    one = lavm_pkg::FX_ONE;
    fail_count          = 0;
    handed_mode         = 1'b0;
    stalls_on           = 1'b0;
    gaps_on             = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.right_handed = 1'b0;
    cam_ch.valid        = 1'b0;
    cam_ch.eye_x = 0; cam_ch.eye_y = 0; cam_ch.eye_z = 0;
    cam_ch.target_x = 0; cam_ch.target_y = 0; cam_ch.target_z = 0;
    cam_ch.up_x = 0; cam_ch.up_y = 0; cam_ch.up_z = 0;
    row_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ordinary camera, extremes, degenerate setups
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, one, 0, one, 0));
    pending_reqs.push_back(make_req(one, 2 * one, -3 * one, 0, 0, 0, 0, one, 0));
    pending_reqs.push_back(make_req(mn, mn, mn, mx, mx, mx, 0, one, 0));
    pending_reqs.push_back(make_req(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    pending_reqs.push_back(make_req(mx, mn, mx, mn, mx, mn, mn, mn, mn));
    pending_reqs.push_back(make_req(mn, mx, 0, mn, mx, one, mx, mx, mx));
    pending_reqs.push_back(make_req(5, 6, 7, 5, 6, 7, 0, one, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, one, 0, 0, one));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, one, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(-1, -1, -1, 0, 0, 0, 1, -1, 1));
    pending_reqs.push_back(make_req(mx, mx, mx, mx, mx, mx - 1, mn, 0, mx));
    pending_reqs.push_back(make_req(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    wait_drained();

    write_handedness(1'b1);
    pending_reqs.push_back(make_req(0, 0, 0, 0, 0, one, 0, one, 0));
    pending_reqs.push_back(make_req(mn, mn, mn, mx, mx, mx, mn, mx, mn));
    pending_reqs.push_back(make_req(mx, mn, mx, mn, mx, mn, 0, one, 0));
    stalls_on = 1'b1;
    gaps_on   = 1'b1;
    run_random(140);

    write_handedness(1'b0);
    stalls_on = 1'b0;
    run_random(120);

    write_handedness(1'b1);
    stalls_on = 1'b1;
    gaps_on   = 1'b0;
    run_random(100);

    write_handedness(1'b0);
    gaps_on = 1'b1;
    run_random(90);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // flag expectations left over is covered by wait_drained; a stuck row trips the watchdog

endmodule

// ===== sim.f =====
design/lavm_pkg.sv
design/lavm_ifs.sv
design/lavm_norm.sv
design/look_at_view_matrix.sv
design/lavm_chk.sv
tb/sv/tb_look_at_view_matrix.sv
